// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of the map table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted.
`define BSMT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define BSMT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bsmt_pkg.sv =====
// Package for the backing-store map table: sizes, operation codes and shared types.
`timescale 1ns / 1ps
`default_nettype none

package bsmt_pkg;

    // table sizing
    localparam int STORE_COUNT     = 8;
    localparam int PAGES_PER_STORE = 256;
    localparam int PROC_COUNT      = 50;
    localparam int PAGE_SHIFT      = 12;

    // item field widths
    localparam int FUNC_W   = 3;
    localparam int PID_W    = 6;
    localparam int VADDR_W  = 32;
    localparam int SEL_W    = 4;
    localparam int BASE_W   = 20;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 1;
    localparam int INDEX_W  = 3;
    localparam int OFFSET_W = 8;

    // derived widths
    localparam int IDX_W       = (STORE_COUNT > 1) ? $clog2(STORE_COUNT) : 1;
    localparam int PAGE_W      = VADDR_W - PAGE_SHIFT;
    localparam int CMP_W       = (PAGE_W > BASE_W) ? PAGE_W : BASE_W;
    localparam int IN_FIELDS_W = PID_W + VADDR_W + SEL_W + BASE_W + COUNT_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + INDEX_W + OFFSET_W;
    localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 3'd0,
        FUNC_ALLOC  = 3'd1,
        FUNC_FREE   = 3'd2,
        FUNC_MAP    = 3'd3,
        FUNC_LOOKUP = 3'd4
    } t_func;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK  = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_ERR = 1'b1;

    // one input item, pid in the low bits
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COUNT_W-1:0] page_count;
        logic [BASE_W-1:0]  base_page;
        logic [SEL_W-1:0]   store_sel;
        logic [VADDR_W-1:0] virt_addr;
        logic [PID_W-1:0]   pid;
    } t_item;

    // one table entry
    typedef struct packed {
        logic               used;
        logic [PID_W-1:0]   owner;
        logic [BASE_W-1:0]  first;
        logic [COUNT_W-1:0] pages;
    } t_entry;

    // table write command from the execute logic
    typedef struct packed {
        logic             clear_all;
        logic             wr_en;
        logic [IDX_W-1:0] idx;
        t_entry           data;
    } t_wr_cmd;

    // one result item, status in the low bit
    typedef struct packed {
        logic [OFFSET_W-1:0] page_offset;
        logic [INDEX_W-1:0]  store_index;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/bsmt_table.sv =====
// Entry storage of the map table: flip-flop entries with clear-all and one write port.
`timescale 1ns / 1ps
`default_nettype none

module bsmt_table
    import bsmt_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_wr_cmd                   i_wr,
    output t_entry [STORE_COUNT-1:0]       o_entries
);

    t_entry [STORE_COUNT-1:0] r_entries;

    // clear-all wins over a single-entry write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_wr.clear_all) begin
            r_entries <= '0;
        end else if (i_wr.wr_en) begin
            r_entries[i_wr.idx] <= i_wr.data;
        end
    end

    assign o_entries = r_entries;

endmodule

`default_nettype wire

// ===== hw/rtl/bsmt_exec.sv =====
// Execute logic of the map table: decodes one item, searches the entries, forms result and write.
`timescale 1ns / 1ps
`default_nettype none

module bsmt_exec
    import bsmt_pkg::*;
(
    input  wire t_item                     i_item,
    input  wire t_entry [STORE_COUNT-1:0]  i_entries,
    output t_result                        o_result,
    output t_wr_cmd                        o_wr
);

    logic               pid_ok;
    logic               sel_ok;
    logic               count_ok;
    logic [IDX_W-1:0]   sel_idx;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               hit_found;
    logic [IDX_W-1:0]   hit_idx;
    t_entry             hit_entry;
    logic [PAGE_W-1:0]  page;
    logic [CMP_W:0]     diff;
    logic               in_range;

    // argument checks
    assign pid_ok   = {1'b0, i_item.pid} < (PID_W + 1)'(PROC_COUNT);
    assign sel_ok   = {1'b0, i_item.store_sel} < (SEL_W + 1)'(STORE_COUNT);
    assign count_ok = (i_item.page_count != '0) &&
                      (i_item.page_count <= COUNT_W'(PAGES_PER_STORE));
    assign sel_idx  = i_item.store_sel[IDX_W-1:0];

    // lowest free entry and lowest entry owned by pid
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        hit_found  = 1'b0;
        hit_idx    = '0;
        for (int k = STORE_COUNT - 1; k >= 0; k--) begin
            if (!i_entries[k].used) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(k);
            end
            if (i_entries[k].used && (i_entries[k].owner == i_item.pid)) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(k);
            end
        end
    end

    // range check on the first owned entry only
    assign hit_entry = i_entries[hit_idx];
    assign page      = i_item.virt_addr[VADDR_W-1:PAGE_SHIFT];
    assign diff      = {1'b0, CMP_W'(page)} - {1'b0, CMP_W'(hit_entry.first)};
    assign in_range  = !diff[CMP_W] && (diff[CMP_W-1:0] < CMP_W'(hit_entry.pages));

    // result and table write per operation
    always_comb begin
        o_result = '{page_offset: '0, store_index: '0, status: STATUS_ERR};
        o_wr     = '0;
        unique case (t_func'(i_item.func))
            FUNC_CLEAR: begin
                o_wr.clear_all  = 1'b1;
                o_result.status = STATUS_OK;
            end
            FUNC_ALLOC: begin
                if (free_found) begin
                    o_result.status      = STATUS_OK;
                    o_result.store_index = INDEX_W'(free_idx);
                end
            end
            FUNC_FREE: begin
                if (sel_ok) begin
                    o_wr.wr_en      = 1'b1;
                    o_wr.idx        = sel_idx;
                    o_result.status = STATUS_OK;
                end
            end
            FUNC_MAP: begin
                if (pid_ok && sel_ok && count_ok) begin
                    o_wr.wr_en      = 1'b1;
                    o_wr.idx        = sel_idx;
                    o_wr.data       = '{used: 1'b1, owner: i_item.pid,
                                        first: i_item.base_page,
                                        pages: i_item.page_count};
                    o_result.status = STATUS_OK;
                end
            end
            FUNC_LOOKUP: begin
                if (pid_ok && hit_found && in_range) begin
                    o_result.status      = STATUS_OK;
                    o_result.store_index = INDEX_W'(hit_idx);
                    o_result.page_offset = diff[OFFSET_W-1:0];
                end
            end
            default: begin
                o_result.status = STATUS_ERR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/backing_store_map_table_unit.sv =====
// Top level of the backing-store map table: input register, execute pass, result register.
`timescale 1ns / 1ps
`default_nettype none

// Backing-store map table with eight flip-flop entries. One item enters per
// clock while the output is not stalled: the item is held in an input
// register, one combinational pass (parallel owner compare over all entries,
// priority pick, one range subtract) computes the result and the table write,
// and both land at the same edge, so the next item already sees the update.
// The result register may stall on m_axis_tready; the input register keeps
// accepting as long as the result can move on. The table comes out of reset
// empty and needs no clearing pass.
module backing_store_map_table_unit
    import bsmt_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // pid, virt_addr, store_sel, base_page, page_count, zero pad
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // func
    input  wire logic [FUNC_W-1:0]      s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status, store_index, page_offset, zero pad
    output logic [OUT_DATA_W-1:0]       m_axis_tdata
);

    logic     r_in_valid;
    t_item    r_item;
    logic     r_out_valid;
    t_result  r_result;
    logic     advance;
    t_result  exec_result;
    t_wr_cmd  exec_wr;
    t_wr_cmd  tbl_wr;
    t_entry [STORE_COUNT-1:0] entries;

    // item moves from the input register to the result register
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= {s_axis_tuser, s_axis_tdata[IN_FIELDS_W-1:0]};
        end
    end

    bsmt_exec u_exec (
        .i_item    (r_item),
        .i_entries (entries),
        .o_result  (exec_result),
        .o_wr      (exec_wr)
    );

    // table write only when the item actually completes
    always_comb begin
        tbl_wr           = exec_wr;
        tbl_wr.clear_all = exec_wr.clear_all && advance;
        tbl_wr.wr_en     = exec_wr.wr_en && advance;
    end

    bsmt_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .o_entries (entries)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= exec_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_result);

endmodule

`default_nettype wire

// ===== hw/rtl/bsmt_checker.sv =====
// Port-level checker for the map table unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsmt_checker
    import bsmt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tready,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // reset empties the result register
    `BSMT_ASSERT_NR(a_out_idle_after_rst, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // input side is open right after reset
    `BSMT_ASSERT_NR(a_in_ready_after_rst, i_clk, !i_rst_n |=> s_axis_tready, "not ready after reset")

    // a stalled result holds
    `BSMT_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

    // an error result carries zero index and offset
    `BSMT_ASSERT(a_err_zero, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[OUT_FIELDS_W-1:STATUS_W] == '0), "error result not zeroed")

endmodule

bind backing_store_map_table_unit bsmt_checker u_bsmt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
